// ===== sv/rsmst_pkg.sv =====
// Shared types and constants for the range sum/min segment tree.
package rsmst_pkg;
    localparam int NumElem = 256;
    localparam int IdxW    = 8;
    localparam int NodeW   = 9;
    localparam int BndW    = 9;

    localparam logic [2:0] OP_SUM    = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_ASSIGN = 3'd2;
    localparam logic [2:0] OP_MIN    = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    localparam logic signed [63:0] MinEmpty = 64'sd2147483647;

    // controller -> datapath
    typedef struct packed {
        logic             load;      // capture request
        logic             clr_wr;    // write zero at clear address
        logic [NodeW-1:0] clr_addr;
        logic             rd;        // read node at rd_addr
        logic [NodeW-1:0] rd_addr;
        logic             acc;       // fold read data into accumulator
        logic             leaf_wr;   // update leaf from read data
        logic             kid_rd;    // read children of node
        logic             node_wr;   // write node from children read data
        logic             find_chk;  // compare leaf min against threshold
        logic [IdxW-1:0]  find_idx;
        logic             done;      // present result
    } t_ctl;

    typedef struct packed {
        logic [2:0]       op;
        logic [BndW-1:0]  lo;
        logic [BndW-1:0]  hi;
        logic             hit;       // find located an element
    } t_sts;
endpackage

// ===== sv/rsmst_ctrl.sv =====
// Sequencer for node memory walks of the segment tree.
module rsmst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  rsmst_pkg::t_sts   i_sts,
    output rsmst_pkg::t_ctl   o_ctl
);
    import rsmst_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_QRY  = 3'd2;
    localparam logic [2:0] S_LEAF = 3'd3;
    localparam logic [2:0] S_UP   = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_DISP = 3'd7;

    logic [2:0]       r_st, n_st;
    logic [NodeW:0]   r_ctr, n_ctr;     // clear / leaf / node / find counter
    logic [NodeW:0]   r_l, n_l, r_r, n_r;
    logic             r_ph, n_ph;       // 0 = read, 1 = write/accumulate
    logic             r_side, n_side;   // query: 0 left, 1 right
    logic [BndW-1:0]  lo_s, hi_s;

    always_comb begin
        lo_s = (i_sts.lo > BndW'(NumElem)) ? BndW'(NumElem) : i_sts.lo;
        hi_s = (i_sts.hi > BndW'(NumElem)) ? BndW'(NumElem) : i_sts.hi;
    end

    always_comb begin
        n_st = r_st; n_ctr = r_ctr; n_l = r_l; n_r = r_r; n_ph = r_ph;
        n_side = r_side;
        o_ctl = '0;
        o_ctl.clr_addr = r_ctr[NodeW-1:0];
        o_ctl.find_idx = r_ctr[IdxW-1:0];
        unique case (r_st)
            S_CLR: begin
                o_ctl.clr_wr = 1'b1;
                n_ctr = r_ctr + 1'b1;
                if (r_ctr == (NodeW+1)'(2*NumElem-1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    // decided next cycle from captured word
                    n_st = S_DISP;
                end
            end
            S_QRY: begin
                // one node at a time: read, then fold
                if (r_l >= r_r) begin
                    n_st = S_DONE;
                end else if (!r_ph) begin
                    if (r_l[0]) begin
                        o_ctl.rd = 1'b1; o_ctl.rd_addr = r_l[NodeW-1:0];
                        n_ph = 1'b1; n_side = 1'b0;
                    end else if (r_r[0]) begin
                        o_ctl.rd = 1'b1; o_ctl.rd_addr = NodeW'(r_r - 1'b1);
                        n_ph = 1'b1; n_side = 1'b1;
                    end else begin
                        n_l = r_l >> 1; n_r = r_r >> 1;
                    end
                end else begin
                    o_ctl.acc = 1'b1;
                    n_ph = 1'b0;
                    if (!r_side) n_l = r_l + 1'b1;
                    else         n_r = r_r - 1'b1;
                end
            end
            S_LEAF: begin
                if (!r_ph) begin
                    o_ctl.rd = 1'b1; o_ctl.rd_addr = NodeW'(r_ctr);
                    n_ph = 1'b1;
                end else begin
                    o_ctl.leaf_wr = 1'b1;
                    o_ctl.rd_addr = NodeW'(r_ctr);
                    n_ph = 1'b0;
                    if (r_ctr == (NodeW+1)'(NumElem) + (NodeW+1)'(hi_s) - 1'b1) begin
                        n_st = S_UP; n_ctr = (NodeW+1)'(NumElem - 1);
                    end else begin
                        n_ctr = r_ctr + 1'b1;
                    end
                end
            end
            S_UP: begin
                if (!r_ph) begin
                    o_ctl.kid_rd = 1'b1; o_ctl.rd_addr = NodeW'(r_ctr);
                    n_ph = 1'b1;
                end else begin
                    o_ctl.node_wr = 1'b1; o_ctl.rd_addr = NodeW'(r_ctr);
                    n_ph = 1'b0;
                    if (r_ctr == (NodeW+1)'(1)) n_st = S_DONE;
                    n_ctr = r_ctr - 1'b1;
                end
            end
            S_FIND: begin
                if (i_sts.hit || r_ctr >= (NodeW+1)'(hi_s)) begin
                    n_st = S_DONE;
                end else if (!r_ph) begin
                    o_ctl.rd = 1'b1;
                    o_ctl.rd_addr = NodeW'(r_ctr + (NodeW+1)'(NumElem));
                    n_ph = 1'b1;
                end else begin
                    o_ctl.find_chk = 1'b1;
                    n_ph = 1'b0;
                    n_ctr = r_ctr + 1'b1;
                end
            end
            S_DONE: begin
                o_ctl.done = 1'b1;
                n_st = S_IDLE;
            end
            S_DISP: begin
                // dispatch on the captured request
                n_ph = 1'b0;
                if (i_sts.op == OP_SUM || i_sts.op == OP_MIN) begin
                    n_l = (NodeW+1)'(lo_s) + (NodeW+1)'(NumElem);
                    n_r = (NodeW+1)'(hi_s) + (NodeW+1)'(NumElem);
                    n_st = S_QRY;
                end else if ((i_sts.op == OP_ADD || i_sts.op == OP_ASSIGN)
                             && lo_s < hi_s) begin
                    n_ctr = (NodeW+1)'(lo_s) + (NodeW+1)'(NumElem);
                    n_st = S_LEAF;
                end else if (i_sts.op == OP_FIND) begin
                    n_ctr = (NodeW+1)'(lo_s);
                    n_st = S_FIND;
                end else begin
                    n_st = S_DONE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_ctr <= '0; r_l <= '0; r_r <= '0;
            r_ph <= 1'b0; r_side <= 1'b0;
        end else begin
            r_st <= n_st; r_ctr <= n_ctr; r_l <= n_l; r_r <= n_r;
            r_ph <= n_ph; r_side <= n_side;
        end
    end

    assign o_busy = (r_st != S_IDLE);

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.done |=> !o_ctl.done) else $error("double done");
    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !(o_ctl.leaf_wr || o_ctl.node_wr)) else $error("write while idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
endmodule

// ===== sv/rsmst_dp.sv =====
// Node memories, accumulators and result register for the segment tree.
module rsmst_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rsmst_pkg::t_ctl         i_ctl,
    output rsmst_pkg::t_sts         o_sts,
    input  logic [2:0]              i_op,
    input  logic [8:0]              i_range_low,
    input  logic [8:0]              i_range_high,
    input  logic signed [63:0]      i_operand,
    output logic                    o_valid,
    output logic signed [63:0]      o_value_out,
    output logic [7:0]              o_found_index,
    output logic                    o_found
);
    import rsmst_pkg::*;

    logic signed [63:0] mem_sum [2*NumElem];
    logic signed [63:0] mem_min [2*NumElem];
    // read data registers: node or left child, and right child, sum and min
    logic signed [63:0] r_rs, r_rm, r_rs2, r_rm2;
    logic [2:0]       r_op;
    logic [BndW-1:0]  r_lo, r_hi;
    logic signed [63:0] r_x, r_asum, r_amin;
    logic             r_any, r_hit;
    logic [IdxW-1:0]  r_fidx;
    logic             r_valid;
    logic signed [63:0] r_vo;
    logic [IdxW-1:0]  r_fo;
    logic             r_fd;
    logic signed [63:0] leaf_v, cmin;
    logic [NodeW-1:0] kid_a;

    assign kid_a = {i_ctl.rd_addr[NodeW-2:0], 1'b0};
    assign leaf_v = (r_op == OP_ADD) ? r_rs + r_x : r_x;
    assign cmin = (r_any && r_amin < r_rm) ? r_amin : r_rm;

    // port A reads node or left child; port B reads right child
    always_ff @(posedge i_clk) begin
        if (i_ctl.kid_rd) begin
            r_rs <= mem_sum[kid_a]; r_rm <= mem_min[kid_a];
            r_rs2 <= mem_sum[kid_a | NodeW'(1)]; r_rm2 <= mem_min[kid_a | NodeW'(1)];
        end else if (i_ctl.rd) begin
            r_rs <= mem_sum[i_ctl.rd_addr]; r_rm <= mem_min[i_ctl.rd_addr];
        end
        if (i_ctl.clr_wr) begin
            mem_sum[i_ctl.clr_addr] <= '0; mem_min[i_ctl.clr_addr] <= '0;
        end else if (i_ctl.leaf_wr) begin
            mem_sum[i_ctl.rd_addr] <= leaf_v; mem_min[i_ctl.rd_addr] <= leaf_v;
        end else if (i_ctl.node_wr) begin
            mem_sum[i_ctl.rd_addr] <= r_rs + r_rs2;
            mem_min[i_ctl.rd_addr] <= (r_rm < r_rm2) ? r_rm : r_rm2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op <= i_op; r_lo <= i_range_low; r_hi <= i_range_high; r_x <= i_operand;
            r_asum <= '0; r_amin <= MinEmpty; r_fidx <= '0;
        end
        if (i_ctl.acc) begin
            r_asum <= r_asum + r_rs; r_amin <= cmin;
        end
        if (i_ctl.find_chk && r_rm < r_x) r_fidx <= i_ctl.find_idx;
        r_vo <= (r_op == OP_SUM) ? r_asum : (r_op == OP_MIN) ? r_amin : '0;
        r_fo <= r_hit ? r_fidx : '0;
        r_fd <= r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0; r_hit <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_any <= 1'b0; r_hit <= 1'b0;
            end else begin
                if (i_ctl.acc) r_any <= 1'b1;
                if (i_ctl.find_chk && r_rm < r_x) r_hit <= 1'b1;
            end
            r_valid <= i_ctl.done;
        end
    end

    assign o_sts = '{op: r_op, lo: r_lo, hi: r_hi, hit: r_hit};
    assign o_valid = r_valid;
    assign o_value_out = r_vo;
    assign o_found_index = r_fo;
    assign o_found = r_fd;

    a_found_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> r_op == OP_FIND) else $error("found on non-find");
    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && !i_ctl.load) |=> r_hit) else $error("hit dropped");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("valid held");
endmodule

// ===== sv/range_sum_min_segment_tree.sv =====
// Top level: range sum/min segment tree with range add and assign, and find.
// Sum/min fold the nodes on the range border while climbing the levels, then finish;
// find scans the leaves in order until one is below the operand or the range ends.
// Add/assign write each leaf in range, then rebuild the 255 inner nodes.
// One request in flight; start is taken again in the cycle the result word shows.
// After reset a clearing pass zeroes all 512 node memory entries with busy high; no stall.
module range_sum_min_segment_tree (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic [8:0]         i_range_low,
    input  logic [8:0]         i_range_high,
    input  logic signed [63:0] i_operand,
    output logic               o_valid,
    output logic signed [63:0] o_value_out,
    output logic [7:0]         o_found_index,
    output logic               o_found
);
    import rsmst_pkg::*;

    t_ctl ctl;
    t_sts sts;

    rsmst_ctrl u_ctrl (.i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
                       .i_sts(sts), .o_ctl(ctl));

    rsmst_dp u_dp (.i_clk, .i_rst_n, .i_ctl(ctl), .o_sts(sts), .i_op, .i_range_low,
                   .i_range_high, .i_operand, .o_valid, .o_value_out,
                   .o_found_index, .o_found);
endmodule

// ===== tb/sv/tb_range_sum_min_segment_tree.sv =====
// Testbench for the range sum/min segment tree: directed and random requests checked.
`timescale 1ns / 1ps

module tb_range_sum_min_segment_tree;
    import rsmst_pkg::*;

    typedef struct {
        logic signed [63:0] value;
        logic [7:0]         index;
        logic               hit;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_op;
    logic [8:0]         i_range_low;
    logic [8:0]         i_range_high;
    logic signed [63:0] i_operand;
    logic               o_valid;
    logic signed [63:0] o_value_out;
    logic [7:0]         o_found_index;
    logic               o_found;

    // element values as the block should hold them
    logic signed [63:0] elem [NumElem];
    t_answer            answers_due [$];
    int                 err_count;
    bit                 send_gaps;

    range_sum_min_segment_tree dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_operand     (i_operand),
        .o_valid       (o_valid),
        .o_value_out   (o_value_out),
        .o_found_index (o_found_index),
        .o_found       (o_found)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Compute the answer to one request and update the element image.
    function automatic t_answer tree_apply(input logic [2:0] op, input logic [8:0] lo_in,
                                           input logic [8:0] hi_in,
                                           input logic signed [63:0] x);
        t_answer a;
        int lo;
        int hi;
        a.value = '0;
        a.index = '0;
        a.hit   = 1'b0;
        lo = (lo_in > NumElem) ? NumElem : lo_in;
        hi = (hi_in > NumElem) ? NumElem : hi_in;
        case (op)
            OP_SUM: begin
                for (int i = lo; i < hi; i++) a.value += elem[i];
            end
            OP_MIN: begin
                a.value = MinEmpty;
                for (int i = lo; i < hi; i++)
                    if (i == lo || elem[i] < a.value) a.value = elem[i];
            end
            OP_ADD: begin
                for (int i = lo; i < hi; i++) elem[i] += x;
            end
            OP_ASSIGN: begin
                for (int i = lo; i < hi; i++) elem[i] = x;
            end
            OP_FIND: begin
                for (int i = lo; i < hi; i++)
                    if (!a.hit && elem[i] < x) begin
                        a.hit   = 1'b1;
                        a.index = i[7:0];
                    end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [8:0] lo,
                                input logic [8:0] hi, input logic signed [63:0] x);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_op         <= op;
        i_range_low  <= lo;
        i_range_high <= hi;
        i_operand    <= x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        answers_due = {answers_due, tree_apply(op, lo, hi, x)};
    endtask

    // check each result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                report("unexpected result", o_value_out, 64'd0);
            end else begin
                t_answer w;
                w = answers_due.pop_front();
                if (o_value_out !== w.value) report("value_out", o_value_out, w.value);
                if (o_found !== w.hit) report("found", 64'(o_found), 64'(w.hit));
                if (o_found_index !== w.index)
                    report("found_index", 64'(o_found_index), 64'(w.index));
            end
        end
    end

    function automatic logic signed [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic signed [63:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return rand_word();
            1: return 64'sh7fffffffffffffff;
            2: return 64'sh8000000000000000;
            default: return $signed(64'($urandom_range(0, 200))) - 100;
        endcase
    endfunction

    function automatic logic [8:0] rand_bound();
        if ($urandom_range(0, 15) == 0) return 9'($urandom_range(256, 511));
        return 9'($urandom_range(0, 256));
    endfunction

    task automatic test_directed();
        send_request(OP_SUM, 0, 256, 0);
        send_request(OP_MIN, 0, 256, 0);
        send_request(OP_FIND, 0, 256, 1);
        for (int i = 0; i < 6; i++) send_request(OP_ASSIGN, i, i + 1, rand_word());
        send_request(OP_ASSIGN, 255, 256, 64'sh8000000000000000);
        send_request(OP_ASSIGN, 254, 255, 64'sh7fffffffffffffff);
        send_request(OP_ADD, 250, 511, 64'sh7fffffffffffffff);   // bounds past the end
        send_request(OP_SUM, 0, 256, 0);                         // wraps
        send_request(OP_MIN, 0, 256, 0);
        send_request(OP_MIN, 10, 10, 0);                         // empty range
        send_request(OP_SUM, 300, 100, 0);
        send_request(OP_FIND, 5, 2, 64'sh7fffffffffffffff);
        send_request(OP_ADD, 9, 3, 5);
        send_request(OP_FIND, 0, 256, 64'sh8000000000000000);    // nothing below
        send_request(OP_FIND, 0, 511, 64'sh7fffffffffffffff);
        send_request(3'd5, 0, 256, -1);
        send_request(3'd6, 1, 2, 3);
        send_request(3'd7, 511, 511, -1);
        send_request(OP_ASSIGN, 0, 256, -7);
        send_request(OP_SUM, 0, 256, 0);
    endtask

    task automatic test_random(input int n);
        logic [2:0] op;
        logic [8:0] lo;
        logic [8:0] hi;
        int         pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 8);
            op = (pick > 7) ? OP_ASSIGN : 3'(pick);
            lo = rand_bound();
            hi = rand_bound();
            // keep updates mostly short so the run stays brief
            if ((op == OP_ADD || op == OP_ASSIGN) && $urandom_range(0, 3) != 0)
                hi = lo + 9'($urandom_range(0, 4));
            send_request(op, lo, hi, rand_operand());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= '0;
        i_range_low  <= '0;
        i_range_high <= '0;
        i_operand    <= '0;
        err_count    = 0;
        send_gaps    = 1'b1;
        for (int i = 0; i < NumElem; i++) elem[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(850);
        send_gaps = 1'b0;
        test_random(150);
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/rsmst_pkg.sv
sv/rsmst_ctrl.sv
sv/rsmst_dp.sv
sv/range_sum_min_segment_tree.sv
tb/sv/tb_range_sum_min_segment_tree.sv
